// ===== rtl/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg - shared types and constants of the safety interlock supervisor
// Request codes, register indexes, field widths and the flag and result
// structures passed between the update logic and the top level.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int TEMP_W = 19;
    localparam int MS_W   = 16;
    localparam int IDX_W  = 2;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [MS_W-1:0]          ms_t;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_STARTUP = 2'd1,
        REQ_MONITOR = 2'd2,
        REQ_KICK    = 2'd3
    } req_t;

    localparam logic [IDX_W-1:0] CFG_THROTTLE_ON  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_THROTTLE_OFF = 2'd1;
    localparam logic [IDX_W-1:0] CFG_WD_TIMEOUT   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_HB_PERIOD    = 2'd3;

    localparam temp_t RST_THROTTLE_ON  = 19'sd85000;
    localparam temp_t RST_THROTTLE_OFF = 19'sd80000;
    localparam ms_t   RST_WD_TIMEOUT   = 16'd1000;
    localparam ms_t   RST_HB_PERIOD    = 16'd500;

    // single-bit supervisor state
    typedef struct packed {
        logic first_pass;
        logic heartbeat;
        logic throttle;
        logic passed;
        logic degraded;
    } flags_t;

    localparam flags_t FLAGS_RST = '{
        first_pass: 1'b1, heartbeat: 1'b0, throttle: 1'b0, passed: 1'b0, degraded: 1'b0
    };

    typedef struct packed {
        logic safe;
        logic go_ahead;
        logic degraded;
        logic startup_passed;
        logic throttled;
        logic watchdog_alive;
        logic watchdog_pet;
        logic heartbeat_level;
        logic heartbeat_toggled;
        logic fire_force_low;
    } result_t;

    typedef struct packed {
        temp_t throttle_on;
        temp_t throttle_off;
        ms_t   wd_timeout;
        ms_t   hb_period;
    } cfg_t;

endpackage

// ===== rtl/sis_update.sv =====
// ----------------------------------------------------------------------------
// sis_update - next-state and result logic for one transaction
// Works out the new supervisor state and the result word from the current
// state, the configuration and one accepted request.
// ----------------------------------------------------------------------------
module sis_update #(
    parameter int AGE_BITS = 16
) (
    input  sis_pkg::req_t            req_type,
    input  logic                     camera_present,
    input  logic                     gpio_defaults_ok,
    input  logic                     tof_ping_ok,
    input  logic                     tof_healthy,
    input  sis_pkg::temp_t           temperature_mdeg,
    input  sis_pkg::cfg_t            cfg,
    input  sis_pkg::flags_t          flags,
    input  logic [AGE_BITS-1:0]      kick_age,
    input  logic [AGE_BITS-1:0]      toggle_age,
    output sis_pkg::flags_t          flags_next,
    output logic [AGE_BITS-1:0]      kick_age_next,
    output logic [AGE_BITS-1:0]      toggle_age_next,
    output sis_pkg::result_t         result
);

    localparam int CMP_W = (AGE_BITS > sis_pkg::MS_W) ? AGE_BITS : sis_pkg::MS_W;

    logic [AGE_BITS-1:0] kick_inc;
    logic [AGE_BITS-1:0] toggle_inc;
    logic                hb_due;
    logic                alive;
    logic                go_ahead;
    logic                pet;
    logic                toggled;
    logic                force_low;

    // saturating millisecond counters
    assign kick_inc   = (&kick_age)   ? kick_age   : kick_age   + AGE_BITS'(1);
    assign toggle_inc = (&toggle_age) ? toggle_age : toggle_age + AGE_BITS'(1);

    assign hb_due = flags.first_pass ||
                    (CMP_W'(toggle_age) >= CMP_W'(cfg.hb_period));

    always_comb begin
        flags_next      = flags;
        kick_age_next   = kick_age;
        toggle_age_next = toggle_age;
        go_ahead        = 1'b0;
        pet             = 1'b0;
        toggled         = 1'b0;
        force_low       = 1'b0;
        case (req_type)
            sis_pkg::REQ_TICK: begin
                kick_age_next   = kick_inc;
                toggle_age_next = toggle_inc;
            end
            sis_pkg::REQ_STARTUP: begin
                force_low = 1'b1;
                if (camera_present && gpio_defaults_ok) begin
                    go_ahead            = 1'b1;
                    flags_next.passed   = 1'b1;
                    flags_next.degraded = !tof_ping_ok;
                end
            end
            sis_pkg::REQ_MONITOR: begin
                // turn-on test wins when thresholds overlap
                if (temperature_mdeg >= cfg.throttle_on) begin
                    flags_next.throttle = 1'b1;
                end else if (temperature_mdeg <= cfg.throttle_off) begin
                    flags_next.throttle = 1'b0;
                end
                if (hb_due) begin
                    flags_next.first_pass = 1'b0;
                    flags_next.heartbeat  = !flags.heartbeat;
                    toggle_age_next       = '0;
                    toggled               = 1'b1;
                end
                if (flags.degraded && tof_ping_ok) begin
                    flags_next.degraded = 1'b0;
                end
            end
            sis_pkg::REQ_KICK: begin
                kick_age_next = '0;
                pet           = 1'b1;
            end
            default: begin
                kick_age_next = kick_age;
            end
        endcase
    end

    // saturated age means expired regardless of timeout
    assign alive = !(&kick_age_next) &&
                   (CMP_W'(kick_age_next) < CMP_W'(cfg.wd_timeout));

    always_comb begin
        result.safe              = flags_next.passed && !flags_next.degraded &&
                                   !flags_next.throttle && alive && tof_healthy;
        result.go_ahead          = go_ahead;
        result.degraded          = flags_next.degraded;
        result.startup_passed    = flags_next.passed;
        result.throttled         = flags_next.throttle;
        result.watchdog_alive    = alive;
        result.watchdog_pet      = pet;
        result.heartbeat_level   = flags_next.heartbeat;
        result.heartbeat_toggled = toggled;
        result.fire_force_low    = force_low;
    end

endmodule

// ===== rtl/safety_interlock_supervisor.sv =====
// ----------------------------------------------------------------------------
// safety_interlock_supervisor - fire output interlock supervisor
// Tracks startup checks, thermal throttling, heartbeat and watchdog age, and
// reports one status result per request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one request transaction per handshake; s_req_type
//   selects a 1 ms tick, a startup check, a monitor pass or a watchdog kick.
//   Result channel (m_*): exactly one result transaction per request, in
//   order, carrying the flags after that request's update.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_idx
//   (0 throttle on, 1 throttle off, 2 watchdog timeout, 3 heartbeat period)
//   in the same cycle. Write only while the block is idle.
//   The state update and result are formed by a single pass of the update
//   logic and land in the state and result registers at the accepting edge.
//   Throughput is one transaction per cycle while m_ready stays high, set by
//   the single result register, which is refilled in the cycle it is drained.
//   When the receiver stalls, s_ready drops once the result register is full
//   and rises again in the cycle m_ready returns.
//   Reset (aresetn low, synchronous) restores the register defaults, clears
//   every flag but first_pass, which is set, sets the kick age saturated
//   (watchdog expired until the first kick) and empties the result register.
// ----------------------------------------------------------------------------
module safety_interlock_supervisor #(
    parameter int AGE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [sis_pkg::IDX_W-1:0]     cfg_idx,
    input  logic [sis_pkg::TEMP_W-1:0]    cfg_wdata,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic                          s_camera_present,
    input  logic                          s_gpio_defaults_ok,
    input  logic                          s_tof_ping_ok,
    input  logic                          s_tof_healthy,
    input  logic signed [sis_pkg::TEMP_W-1:0] s_temperature_mdeg,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_safe,
    output logic                          m_go_ahead,
    output logic                          m_degraded,
    output logic                          m_startup_passed,
    output logic                          m_throttled,
    output logic                          m_watchdog_alive,
    output logic                          m_watchdog_pet,
    output logic                          m_heartbeat_level,
    output logic                          m_heartbeat_toggled,
    output logic                          m_fire_force_low
);

    // configuration registers
    sis_pkg::cfg_t       cfg_reg;

    // supervisor state
    sis_pkg::flags_t     flags_reg;
    sis_pkg::flags_t     flags_next;
    logic [AGE_BITS-1:0] kick_age_reg;
    logic [AGE_BITS-1:0] kick_age_next;
    logic [AGE_BITS-1:0] toggle_age_reg;
    logic [AGE_BITS-1:0] toggle_age_next;

    // result register
    logic                m_valid_reg;
    sis_pkg::result_t    result_reg;
    sis_pkg::result_t    result_next;

    logic                s_accept;

    // result slot free, or being emptied this cycle
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    sis_update #(
        .AGE_BITS (AGE_BITS)
    ) u_update (
        .req_type         (sis_pkg::req_t'(s_req_type)),
        .camera_present   (s_camera_present),
        .gpio_defaults_ok (s_gpio_defaults_ok),
        .tof_ping_ok      (s_tof_ping_ok),
        .tof_healthy      (s_tof_healthy),
        .temperature_mdeg (s_temperature_mdeg),
        .cfg              (cfg_reg),
        .flags            (flags_reg),
        .kick_age         (kick_age_reg),
        .toggle_age       (toggle_age_reg),
        .flags_next       (flags_next),
        .kick_age_next    (kick_age_next),
        .toggle_age_next  (toggle_age_next),
        .result           (result_next)
    );

    // configuration writes, no handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.throttle_on  <= sis_pkg::RST_THROTTLE_ON;
            cfg_reg.throttle_off <= sis_pkg::RST_THROTTLE_OFF;
            cfg_reg.wd_timeout   <= sis_pkg::RST_WD_TIMEOUT;
            cfg_reg.hb_period    <= sis_pkg::RST_HB_PERIOD;
        end else if (cfg_wr_en) begin
            case (cfg_idx)
                sis_pkg::CFG_THROTTLE_ON:  cfg_reg.throttle_on  <= cfg_wdata;
                sis_pkg::CFG_THROTTLE_OFF: cfg_reg.throttle_off <= cfg_wdata;
                sis_pkg::CFG_WD_TIMEOUT:   cfg_reg.wd_timeout   <= cfg_wdata[sis_pkg::MS_W-1:0];
                sis_pkg::CFG_HB_PERIOD:    cfg_reg.hb_period    <= cfg_wdata[sis_pkg::MS_W-1:0];
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // state advances only on an accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg      <= sis_pkg::FLAGS_RST;
            kick_age_reg   <= '1;
            toggle_age_reg <= '0;
        end else if (s_accept) begin
            flags_reg      <= flags_next;
            kick_age_reg   <= kick_age_next;
            toggle_age_reg <= toggle_age_next;
        end
    end

    // result register: valid flag reset, payload loaded on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_safe              = result_reg.safe;
    assign m_go_ahead          = result_reg.go_ahead;
    assign m_degraded          = result_reg.degraded;
    assign m_startup_passed    = result_reg.startup_passed;
    assign m_throttled         = result_reg.throttled;
    assign m_watchdog_alive    = result_reg.watchdog_alive;
    assign m_watchdog_pet      = result_reg.watchdog_pet;
    assign m_heartbeat_level   = result_reg.heartbeat_level;
    assign m_heartbeat_toggled = result_reg.heartbeat_toggled;
    assign m_fire_force_low    = result_reg.fire_force_low;

    // a kick transaction yields a pet pulse in the next result
    a_kick_pets: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_req_type == sis_pkg::REQ_KICK)) |=> (m_valid && m_watchdog_pet))
        else $error("kick did not produce a pet result");

    // a startup check always forces the fire output low
    a_startup_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_req_type == sis_pkg::REQ_STARTUP)) |=> (m_valid && m_fire_force_low))
        else $error("startup check without fire force low");

    // safe implies every reported contributing condition holds
    a_safe_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_safe) |-> (m_startup_passed && !m_degraded && !m_throttled &&
                                 m_watchdog_alive))
        else $error("safe reported with a failing condition");

    // a kick leaves the saturated state, so the next tick cannot saturate the age
    a_kick_clears_age: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_req_type == sis_pkg::REQ_KICK)) |=> (kick_age_reg == '0))
        else $error("kick did not restart the watchdog age");

endmodule

// ===== sim/sis_status_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_status_checker - status predictor and comparator for the supervisor
// Follows register writes and request transactions, works out the status that
// each request should produce and compares the result channel against it in
// order, one field at a time.
// ----------------------------------------------------------------------------
module sis_status_checker #(
    parameter int AGE_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [sis_pkg::IDX_W-1:0]  cfg_idx,
    input  logic [sis_pkg::TEMP_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [1:0]                 s_req_type,
    input  logic                       s_camera_present,
    input  logic                       s_gpio_defaults_ok,
    input  logic                       s_tof_ping_ok,
    input  logic                       s_tof_healthy,
    input  sis_pkg::temp_t             s_temperature_mdeg,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_safe,
    input  logic                       m_go_ahead,
    input  logic                       m_degraded,
    input  logic                       m_startup_passed,
    input  logic                       m_throttled,
    input  logic                       m_watchdog_alive,
    input  logic                       m_watchdog_pet,
    input  logic                       m_heartbeat_level,
    input  logic                       m_heartbeat_toggled,
    input  logic                       m_fire_force_low,
    output int                         mismatch_count,
    output int                         results_owed
);

    localparam logic [AGE_BITS-1:0] AGE_SAT = '1;
    localparam int RESULT_W  = $bits(sis_pkg::result_t);
    localparam int PRINT_CAP = 200;

    // supervisor copy: settings, ages and flags
    sis_pkg::temp_t      thr_on;
    sis_pkg::temp_t      thr_off;
    sis_pkg::ms_t        wd_limit;
    sis_pkg::ms_t        hb_period;
    logic [AGE_BITS-1:0] kick_age;
    logic [AGE_BITS-1:0] toggle_age;
    logic                first_pass;
    logic                hb_level;
    logic                throttling;
    logic                passed;
    logic                degraded;

    sis_pkg::result_t status_due [$];
    int               results_checked;
    int               errors;

    // MSB first, as in result_t
    string field_names [RESULT_W] = '{
        "safe", "go_ahead", "degraded", "startup_passed", "throttled",
        "watchdog_alive", "watchdog_pet", "heartbeat_level", "heartbeat_toggled",
        "fire_force_low"
    };

    assign mismatch_count = errors;

    task automatic flag_mismatch(input string what);
        if (errors < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        errors++;
    endtask

    function automatic logic [AGE_BITS-1:0] age_step(input logic [AGE_BITS-1:0] age);
        return (age == AGE_SAT) ? age : age + AGE_BITS'(1);
    endfunction

    task automatic advance_supervisor(input sis_pkg::req_t kind, input logic cam,
                                      input logic gpio, input logic ping,
                                      input logic healthy, input sis_pkg::temp_t temp,
                                      output sis_pkg::result_t status);
        logic alive;
        status = '0;
        case (kind)
            sis_pkg::REQ_TICK: begin
                kick_age   = age_step(kick_age);
                toggle_age = age_step(toggle_age);
            end
            sis_pkg::REQ_STARTUP: begin
                status.fire_force_low = 1'b1;
                // a failed hard check leaves passed and degraded alone
                if (cam && gpio) begin
                    status.go_ahead = 1'b1;
                    passed          = 1'b1;
                    degraded        = !ping;
                end
            end
            sis_pkg::REQ_MONITOR: begin
                // turn-on test first, so overlapping thresholds favour throttling
                if (temp >= thr_on) begin
                    throttling = 1'b1;
                end else if (temp <= thr_off) begin
                    throttling = 1'b0;
                end
                if (first_pass || toggle_age >= hb_period) begin
                    first_pass               = 1'b0;
                    hb_level                 = !hb_level;
                    toggle_age               = '0;
                    status.heartbeat_toggled = 1'b1;
                end
                if (degraded && ping) begin
                    degraded = 1'b0;
                end
            end
            default: begin
                kick_age            = '0;
                status.watchdog_pet = 1'b1;
            end
        endcase
        alive = (kick_age != AGE_SAT) && (kick_age < wd_limit);
        status.safe            = passed && !degraded && !throttling && alive && healthy;
        status.degraded        = degraded;
        status.startup_passed  = passed;
        status.throttled       = throttling;
        status.watchdog_alive  = alive;
        status.heartbeat_level = hb_level;
    endtask

    always @(posedge aclk) begin
        sis_pkg::result_t predicted;
        sis_pkg::result_t observed;
        if (!aresetn) begin
            thr_on     = sis_pkg::RST_THROTTLE_ON;
            thr_off    = sis_pkg::RST_THROTTLE_OFF;
            wd_limit   = sis_pkg::RST_WD_TIMEOUT;
            hb_period  = sis_pkg::RST_HB_PERIOD;
            kick_age   = AGE_SAT;
            toggle_age = '0;
            first_pass = 1'b1;
            hb_level   = 1'b0;
            throttling = 1'b0;
            passed     = 1'b0;
            degraded   = 1'b0;
            status_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx)
                    sis_pkg::CFG_THROTTLE_ON:  thr_on    = sis_pkg::temp_t'(cfg_wdata);
                    sis_pkg::CFG_THROTTLE_OFF: thr_off   = sis_pkg::temp_t'(cfg_wdata);
                    sis_pkg::CFG_WD_TIMEOUT:   wd_limit  = cfg_wdata[sis_pkg::MS_W-1:0];
                    sis_pkg::CFG_HB_PERIOD:    hb_period = cfg_wdata[sis_pkg::MS_W-1:0];
                    default: ;
                endcase
            end
            // a result leaving on this edge belongs to an earlier request
            if (m_valid && m_ready) begin
                observed = {m_safe, m_go_ahead, m_degraded, m_startup_passed, m_throttled,
                            m_watchdog_alive, m_watchdog_pet, m_heartbeat_level,
                            m_heartbeat_toggled, m_fire_force_low};
                if (status_due.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with nothing outstanding (%b)",
                                            results_checked, observed));
                end else begin
                    predicted = status_due.pop_front();
                    for (int i = 0; i < RESULT_W; i++) begin
                        if (predicted[RESULT_W-1-i] !== observed[RESULT_W-1-i]) begin
                            flag_mismatch($sformatf("result %0d %s: expected %b, got %b",
                                                    results_checked, field_names[i],
                                                    predicted[RESULT_W-1-i],
                                                    observed[RESULT_W-1-i]));
                        end
                    end
                end
                results_checked++;
            end
            if (s_valid && s_ready) begin
                advance_supervisor(sis_pkg::req_t'(s_req_type), s_camera_present,
                                   s_gpio_defaults_ok, s_tof_ping_ok, s_tof_healthy,
                                   s_temperature_mdeg, predicted);
                status_due.push_back(predicted);
            end
        end
        results_owed <= status_due.size();
    end

endmodule

// ===== sim/safety_interlock_supervisor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safety_interlock_supervisor_test - top level of the supervisor testbench
// Drives request transactions and register settings into the supervisor,
// stalls the result channel on a pattern of its own and leaves prediction and
// comparison to the checker beside it. A directed opening covers the corner
// cases and random phases under several settings follow.
// ----------------------------------------------------------------------------
module safety_interlock_supervisor_test;

    localparam int AGE_BITS     = 16;
    localparam int RESET_CYCLES = 12;
    // the limit leaves ample room for a full run, even with the receiver stalling
    // heavily throughout
    localparam int CYCLE_LIMIT  = 50_000;
    localparam int DRAIN_LIMIT  = 2000;
    // spare cycles after the drain, before touching settings
    localparam int TAIL_CYCLES  = 4;

    // receiver behaviour, changed after each random span
    typedef enum {
        RX_STREAM,
        RX_CHOPPY,
        RX_SLUGGISH
    } rx_mode_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [sis_pkg::IDX_W-1:0]  cfg_idx;
    logic [sis_pkg::TEMP_W-1:0] cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic [1:0]                 s_req_type;
    logic                       s_camera_present;
    logic                       s_gpio_defaults_ok;
    logic                       s_tof_ping_ok;
    logic                       s_tof_healthy;
    sis_pkg::temp_t             s_temperature_mdeg;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_safe;
    logic                       m_go_ahead;
    logic                       m_degraded;
    logic                       m_startup_passed;
    logic                       m_throttled;
    logic                       m_watchdog_alive;
    logic                       m_watchdog_pet;
    logic                       m_heartbeat_level;
    logic                       m_heartbeat_toggled;
    logic                       m_fire_force_low;

    int                         mismatch_count;
    int                         results_owed;
    int                         cycle_count;
    int                         burst_left;
    int                         cur_on;
    int                         cur_off;
    rx_mode_t                   rx_mode;

    safety_interlock_supervisor #(
        .AGE_BITS (AGE_BITS)
    ) u_top (.*);

    sis_status_checker #(
        .AGE_BITS (AGE_BITS)
    ) u_checker (.*);

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog on the run itself: a hung handshake ends here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[%0t] timeout after %0d cycles, %0d results owed",
                 $time, cycle_count, results_owed);
        $display("Simulation FAILED");
        $finish;
    end

    // Result channel back-pressure: random spans of free flow, light stalling
    // and heavy stalling follow each other, so gaps land on every phase of work.
    initial begin
        int span;
        m_ready = 1'b0;
        forever begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            span    = $urandom_range(16, 200);
            repeat (span) begin
                @(posedge aclk);
                case (rx_mode)
                    RX_STREAM: m_ready <= 1'b1;
                    RX_CHOPPY: m_ready <= ($urandom_range(0, 3) != 0);
                    default:   m_ready <= ($urandom_range(0, 4) < 2);
                endcase
            end
        end
    end

    // One request transaction: valid is raised with the payload and held
    // until the edge at which ready is also high. Signals are read straight
    // after the edge, so they hold the values the block saw on it.
    task automatic send_request(input sis_pkg::req_t kind, input logic cam, input logic gpio,
                                input logic ping, input logic healthy,
                                input sis_pkg::temp_t temp);
        s_valid            <= 1'b1;
        s_req_type         <= kind;
        s_camera_present   <= cam;
        s_gpio_defaults_ok <= gpio;
        s_tof_ping_ok      <= ping;
        s_tof_healthy      <= healthy;
        s_temperature_mdeg <= temp;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Same, followed by the sender's burst and gap pattern. Valid is only
    // lowered when a gap follows, so it never drops
    // and rises within one step.
    task automatic send_paced(input sis_pkg::req_t kind, input logic cam, input logic gpio,
                              input logic ping, input logic healthy,
                              input sis_pkg::temp_t temp);
        send_request(kind, cam, gpio, ping, healthy, temp);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 300)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Hold the sender off until every outstanding result has been taken.
    task automatic wait_idle();
        s_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && (n == 0 || results_owed != 0); n++) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Writes all four registers on consecutive edges; enable stays high
    // throughout and drops once after the last one.
    task automatic load_settings(input int on, input int off, input int tmo, input int per);
        logic [sis_pkg::IDX_W-1:0]  regs [4];
        logic [sis_pkg::TEMP_W-1:0] vals [4];
        regs = '{sis_pkg::CFG_THROTTLE_ON, sis_pkg::CFG_THROTTLE_OFF,
                 sis_pkg::CFG_WD_TIMEOUT, sis_pkg::CFG_HB_PERIOD};
        vals = '{sis_pkg::TEMP_W'(on), sis_pkg::TEMP_W'(off),
                 sis_pkg::TEMP_W'(tmo & 'hFFFF), sis_pkg::TEMP_W'(per & 'hFFFF)};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_idx   <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        cur_on  = on;
        cur_off = off;
    endtask

    // Random phase under one setting. Startup checks mostly pass their hard
    // checks and kicks are frequent, so the safe flag is reached often; runs
    // of ticks let the watchdog lapse and the heartbeat fall due.
    task automatic run_phase(input int on, input int off, input int tmo, input int per,
                             input int items);
        int            sent;
        int            span;
        int            run_len;
        int            pick;
        int            v;
        sis_pkg::req_t kind;
        wait_idle();
        load_settings(on, off, tmo, per);
        span = (tmo > per) ? tmo : per;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 49) == 0) begin
                wait_idle();
            end
            if ($urandom_range(0, 24) == 0) begin
                run_len = $urandom_range(1, (span > 60) ? 150 : 2 * span + 3);
                repeat (run_len) begin
                    send_paced(sis_pkg::REQ_TICK, 1'($urandom), 1'($urandom), 1'($urandom),
                               ($urandom_range(0, 7) != 0), sis_pkg::temp_t'($urandom));
                end
                sent += run_len;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                kind = sis_pkg::REQ_TICK;
            end else if (pick < 65) begin
                kind = sis_pkg::REQ_MONITOR;
            end else if (pick < 82) begin
                kind = sis_pkg::REQ_KICK;
            end else begin
                kind = sis_pkg::REQ_STARTUP;
            end
            // temperatures cluster on the thresholds, with some spread and
            // the odd full-width value
            pick = $urandom_range(0, 19);
            if (pick < 7) begin
                v = cur_on + int'($urandom_range(0, 6)) - 3;
            end else if (pick < 14) begin
                v = cur_off + int'($urandom_range(0, 6)) - 3;
            end else if (pick < 19) begin
                v = int'($urandom_range(0, 190000)) - 40000;
            end else begin
                v = int'($urandom);
            end
            send_paced(kind, ($urandom_range(0, 9) != 0), ($urandom_range(0, 9) != 0),
                       ($urandom_range(0, 3) != 0), ($urandom_range(0, 7) != 0),
                       sis_pkg::temp_t'(v));
            sent++;
        end
    endtask

    initial begin
        aresetn            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_idx            = sis_pkg::CFG_THROTTLE_ON;
        cfg_wdata          = '0;
        s_valid            = 1'b0;
        s_req_type         = sis_pkg::REQ_TICK;
        s_camera_present   = 1'b0;
        s_gpio_defaults_ok = 1'b0;
        s_tof_ping_ok      = 1'b0;
        s_tof_healthy      = 1'b0;
        s_temperature_mdeg = '0;
        burst_left         = 0;
        cur_on             = 85000;
        cur_off            = 80000;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed opening, reset settings ---
        // first monitor pass always toggles the heartbeat
        send_paced(sis_pkg::REQ_MONITOR, 1'b0, 1'b0, 1'b0, 1'b1, sis_pkg::temp_t'(-40000));
        // kick age saturated from reset: watchdog expired, tick keeps it there
        send_paced(sis_pkg::REQ_TICK,    1'b0, 1'b0, 1'b0, 1'b1, sis_pkg::temp_t'(0));
        // hard check failures, each flag on its own
        send_paced(sis_pkg::REQ_STARTUP, 1'b0, 1'b1, 1'b1, 1'b1, sis_pkg::temp_t'(0));
        send_paced(sis_pkg::REQ_STARTUP, 1'b1, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(0));
        send_paced(sis_pkg::REQ_KICK,    1'b0, 1'b0, 1'b0, 1'b1, sis_pkg::temp_t'(0));
        // soft failure: proceeds, passed and degraded
        send_paced(sis_pkg::REQ_STARTUP, 1'b1, 1'b1, 1'b0, 1'b1, sis_pkg::temp_t'(0));
        // later hard failure keeps passed and degraded as they were
        send_paced(sis_pkg::REQ_STARTUP, 1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(0));
        // hysteresis around the reset thresholds; ping clears degraded
        send_paced(sis_pkg::REQ_MONITOR, 1'b0, 1'b0, 1'b0, 1'b1, sis_pkg::temp_t'(150000));
        send_paced(sis_pkg::REQ_MONITOR, 1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(82000));
        send_paced(sis_pkg::REQ_MONITOR, 1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(80000));
        send_paced(sis_pkg::REQ_MONITOR, 1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(85000));
        send_paced(sis_pkg::REQ_MONITOR, 1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(80001));
        send_paced(sis_pkg::REQ_MONITOR, 1'b1, 1'b1, 1'b1, 1'b1, sis_pkg::temp_t'(19'h40000));
        // unhealthy rangefinder alone blocks safe
        send_paced(sis_pkg::REQ_TICK,    1'b1, 1'b1, 1'b1, 1'b0, sis_pkg::temp_t'(19'h3FFFF));
        send_paced(sis_pkg::REQ_TICK,    1'b1, 1'b1, 1'b1, 1'b1, sis_pkg::temp_t'(0));
        send_paced(sis_pkg::REQ_MONITOR, 1'b1, 1'b1, 1'b1, 1'b1, sis_pkg::temp_t'(19'h3FFFF));
        send_paced(sis_pkg::REQ_STARTUP, 1'b1, 1'b1, 1'b1, 1'b1, sis_pkg::temp_t'(-1));

        // overlapping thresholds, zero timeout, zero period
        wait_idle();
        load_settings(1000, 5000, 0, 0);
        send_paced(sis_pkg::REQ_KICK,    1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(0));
        send_paced(sis_pkg::REQ_MONITOR, 1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(3000));
        send_paced(sis_pkg::REQ_MONITOR, 1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(500));
        send_paced(sis_pkg::REQ_MONITOR, 1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(5000));
        send_paced(sis_pkg::REQ_TICK,    1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(0));

        // watchdog lapses after two ticks
        wait_idle();
        load_settings(85000, 80000, 2, 1);
        send_paced(sis_pkg::REQ_KICK,    1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(0));
        send_paced(sis_pkg::REQ_TICK,    1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(0));
        send_paced(sis_pkg::REQ_TICK,    1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(0));
        send_paced(sis_pkg::REQ_MONITOR, 1'b0, 1'b0, 1'b1, 1'b1, sis_pkg::temp_t'(0));

        // --- random phases ---
        run_phase(85000, 80000, 1000, 500, 150);
        run_phase(30000, 25000, 8, 5, 250);
        run_phase(150000, -40000, 65535, 65535, 150);
        run_phase(-40000, 150000, 1, 1, 150);
        run_phase(0, 0, 0, 0, 100);
        for (int p = 0; p < 4; p++) begin
            run_phase(int'($urandom_range(0, 190000)) - 40000,
                      int'($urandom_range(0, 190000)) - 40000,
                      $urandom_range(1, 30), $urandom_range(1, 30), 200);
        end

        wait_idle();
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
